/* rtl/sbct_pkg.sv */
package sbct_pkg;

    // reply buffer depth and count widths
    localparam int MAX_WORDS = 32;
    localparam int BUF_AW    = $clog2(MAX_WORDS);
    localparam int CNT_W     = 6;
    localparam logic [CNT_W-1:0] MAX_WORDS_C = CNT_W'(MAX_WORDS);
    localparam logic [CNT_W-1:0] CNT_SAT     = '1;

    // request kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_RX   = 2'd2;

    // result kinds
    localparam logic [1:0] RES_TX      = 2'd0;
    localparam logic [1:0] RES_DATA    = 2'd1;
    localparam logic [1:0] RES_OUTCOME = 2'd2;

    // outcome codes
    localparam logic [2:0] REJ_OK          = 3'd0;
    localparam logic [2:0] REJ_ADDRESS     = 3'd1;
    localparam logic [2:0] REJ_STATUS_PAR  = 3'd2;
    localparam logic [2:0] REJ_LENGTH      = 3'd3;
    localparam logic [2:0] REJ_DATA_PAR    = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  rt_address;
        logic        transmit_dir;
        logic [4:0]  subaddress_mode;
        logic [5:0]  word_count;
        logic [15:0] data_word;
        logic [16:0] bus_word_in;
        logic        rx_last;
    } sbct_req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [16:0] bus_word_out;
        logic [15:0] data_out;
        logic [2:0]  reject_code;
        logic [5:0]  words_accepted;
        logic        last;
    } sbct_res_t;

    // 17-bit word with odd parity in bit 0
    function automatic logic [16:0] with_parity(input logic [15:0] payload);
        return {payload, ~(^payload)};
    endfunction

endpackage

/* rtl/sbct_ram.sv */
module sbct_ram #(
    parameter int Width = 16,
    parameter int Depth = 32,
    localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AddrWidth-1:0] waddr,
    input  logic [Width-1:0]     wdata,
    input  logic [AddrWidth-1:0] raddr,
    output logic [Width-1:0]     rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/serial_bus_command_transaction.sv */
// Bus controller for a command/response serial bus with 17-bit words (16-bit payload, odd
// parity in bit 0). A command request yields the encoded command word; each data request
// to send yields one parity-coded data word while words remain to be sent, and is dropped
// otherwise. The last word of a transmit reply is checked as it is taken, and a reply that
// passes its status and length checks is then read out of the reply buffer RAM, each data
// word through a read-address state and a read-data state (the registered RAM read sets
// this), followed by the outcome; no request is taken during the readout. A request is
// only taken while the output register is empty or being emptied in the same cycle, so a
// result held back by the receiver also holds off the next request. The buffer needs no
// clearing after reset; only entries written in the current reply are ever read back.
module serial_bus_command_transaction (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sbct_pkg::sbct_req_t  s_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sbct_pkg::sbct_res_t  m_result,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);
    import sbct_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_OUTCOME
    } state_t;

    // control and transaction state
    state_t           state_reg, state_next;
    logic             powered_reg, powered_next;
    logic [4:0]       exp_term_reg, exp_term_next;
    logic [CNT_W-1:0] exp_cnt_reg, exp_cnt_next;
    logic [CNT_W-1:0] send_rem_reg, send_rem_next;
    logic [CNT_W-1:0] reply_cnt_reg, reply_cnt_next;
    logic [CNT_W-1:0] bad_idx_reg, bad_idx_next;
    logic             bad_vld_reg, bad_vld_next;
    logic [1:0]       sfault_reg, sfault_next;

    // readout
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [2:0]       code_reg, code_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    sbct_res_t        m_result_reg, m_result_next;

    // reply buffer port
    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;

    // working values for a received word
    logic             out_free;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] rx_idx;
    logic [CNT_W-1:0] cnt_new;
    logic             word_par_ok;
    logic [1:0]       sf_new;
    logic             bv_new;
    logic [CNT_W-1:0] bi_new;
    logic [2:0]       code_new;
    logic [CNT_W-1:0] lim_new;
    sbct_res_t        res;

    sbct_ram #(
        .Width (16),
        .Depth (MAX_WORDS)
    ) u_reply_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[BUF_AW-1:0]),
        .rdata (ram_rdata)
    );

    // the output slot is free when empty or being emptied this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    always_comb begin
        state_next    = state_reg;
        powered_next  = powered_reg;
        exp_term_next = exp_term_reg;
        exp_cnt_next  = exp_cnt_reg;
        send_rem_next = send_rem_reg;
        reply_cnt_next = reply_cnt_reg;
        bad_idx_next  = bad_idx_reg;
        bad_vld_next  = bad_vld_reg;
        sfault_next   = sfault_reg;
        rd_idx_next   = rd_idx_reg;
        limit_next    = limit_reg;
        code_next     = code_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_result_next = m_result_reg;

        ram_we    = 1'b0;
        rx_idx    = reply_cnt_reg - CNT_W'(1);
        ram_waddr = rx_idx[BUF_AW-1:0];
        ram_wdata = s_req.bus_word_in[16:1];

        cnt_eff     = (s_req.word_count > MAX_WORDS_C) ? MAX_WORDS_C : s_req.word_count;
        word_par_ok = ^s_req.bus_word_in;
        cnt_new     = (reply_cnt_reg == CNT_SAT) ? CNT_SAT : reply_cnt_reg + CNT_W'(1);
        sf_new      = sfault_reg;
        bv_new      = bad_vld_reg;
        bi_new      = bad_idx_reg;
        code_new    = REJ_OK;
        lim_new     = '0;
        res         = '0;

        if (cfg_we) begin
            powered_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    case (s_req.kind)
                        KIND_CMD: begin
                            exp_term_next  = s_req.rt_address;
                            reply_cnt_next = '0;
                            bad_vld_next   = 1'b0;
                            bad_idx_next   = '0;
                            sfault_next    = '0;
                            res.result_kind  = RES_TX;
                            res.bus_word_out = with_parity({s_req.rt_address,
                                s_req.transmit_dir, s_req.subaddress_mode,
                                cnt_eff[4:0]});
                            if (!s_req.transmit_dir) begin
                                exp_cnt_next  = '0;
                                send_rem_next = cnt_eff;
                                res.last      = (cnt_eff == '0);
                            end else begin
                                exp_cnt_next  = cnt_eff;
                                send_rem_next = '0;
                                res.last      = 1'b1;
                            end
                            m_valid_next  = 1'b1;
                            m_result_next = res;
                        end
                        KIND_DATA: begin
                            if (send_rem_reg != '0) begin
                                send_rem_next    = send_rem_reg - CNT_W'(1);
                                res.result_kind  = RES_TX;
                                res.bus_word_out = with_parity(s_req.data_word);
                                res.last         = (send_rem_reg == CNT_W'(1));
                                m_valid_next     = 1'b1;
                                m_result_next    = res;
                            end
                        end
                        KIND_RX: begin
                            if (powered_reg) begin
                                if (reply_cnt_reg == '0) begin
                                    // status word
                                    sf_new = {!word_par_ok,
                                              s_req.bus_word_in[16:12] != exp_term_reg};
                                end else if (!rx_idx[CNT_W-1]) begin
                                    // data word inside the buffer
                                    ram_we = 1'b1;
                                    if (!bad_vld_reg && !word_par_ok) begin
                                        bv_new = 1'b1;
                                        bi_new = rx_idx;
                                    end
                                end
                                reply_cnt_next = cnt_new;
                                sfault_next    = sf_new;
                                bad_vld_next   = bv_new;
                                bad_idx_next   = bi_new;

                                if (s_req.rx_last) begin
                                    if (sf_new[0]) begin
                                        code_new = REJ_ADDRESS;
                                    end else if (sf_new[1]) begin
                                        code_new = REJ_STATUS_PAR;
                                    end else if ({1'b0, cnt_new} !=
                                                 {1'b0, exp_cnt_reg} + 7'd1) begin
                                        code_new = REJ_LENGTH;
                                    end else begin
                                        lim_new = exp_cnt_reg;
                                        if (bv_new && (bi_new < exp_cnt_reg)) begin
                                            lim_new  = bi_new;
                                            code_new = REJ_DATA_PAR;
                                        end
                                    end
                                    // the reply is finished either way
                                    reply_cnt_next = '0;
                                    bad_vld_next   = 1'b0;
                                    bad_idx_next   = '0;
                                    sfault_next    = '0;
                                    limit_next     = lim_new;
                                    code_next      = code_new;
                                    if (lim_new == '0) begin
                                        res.result_kind    = RES_OUTCOME;
                                        res.reject_code    = code_new;
                                        res.words_accepted = '0;
                                        res.last           = 1'b1;
                                        m_valid_next       = 1'b1;
                                        m_result_next      = res;
                                    end else begin
                                        rd_idx_next = '0;
                                        state_next  = ST_RD_ADDR;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_ADDR: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    res.result_kind = RES_DATA;
                    res.data_out    = ram_rdata;
                    m_valid_next    = 1'b1;
                    m_result_next   = res;
                    if (rd_idx_reg + CNT_W'(1) == limit_reg) begin
                        state_next = ST_OUTCOME;
                    end else begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                        state_next  = ST_RD_ADDR;
                    end
                end
            end
            ST_OUTCOME: begin
                if (out_free) begin
                    res.result_kind    = RES_OUTCOME;
                    res.reject_code    = code_reg;
                    res.words_accepted = limit_reg;
                    res.last           = 1'b1;
                    m_valid_next       = 1'b1;
                    m_result_next      = res;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            powered_reg   <= 1'b1;
            exp_term_reg  <= '0;
            exp_cnt_reg   <= '0;
            send_rem_reg  <= '0;
            reply_cnt_reg <= '0;
            bad_idx_reg   <= '0;
            bad_vld_reg   <= 1'b0;
            sfault_reg    <= '0;
            rd_idx_reg    <= '0;
            limit_reg     <= '0;
            code_reg      <= REJ_OK;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            powered_reg   <= powered_next;
            exp_term_reg  <= exp_term_next;
            exp_cnt_reg   <= exp_cnt_next;
            send_rem_reg  <= send_rem_next;
            reply_cnt_reg <= reply_cnt_next;
            bad_idx_reg   <= bad_idx_next;
            bad_vld_reg   <= bad_vld_next;
            sfault_reg    <= sfault_next;
            rd_idx_reg    <= rd_idx_next;
            limit_reg     <= limit_next;
            code_reg      <= code_next;
            m_valid_reg   <= m_valid_next;
        end
        m_result_reg <= m_result_next;
    end

    // readout never runs past the accepted word count
    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_ADDR || state_reg == ST_RD_DATA) |-> rd_idx_reg < limit_reg)
        else $error("readout index beyond limit");

    // the buffer is only written by an accepted received word
    a_wr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE && s_valid && s_ready))
        else $error("reply buffer written outside an accepted request");

    // data words are only read out for a reply that passes its status and length checks
    a_rd_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_DATA) |-> (code_reg == REJ_OK || code_reg == REJ_DATA_PAR))
        else $error("readout for a rejected reply");

    // the accepted count fits the buffer
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        limit_reg <= MAX_WORDS_C)
        else $error("accepted word count beyond buffer depth");

endmodule

/* test/tb_serial_bus_command_transaction.sv */
module tb_serial_bus_command_transaction;

    timeunit 1ns;
    timeprecision 1ps;

    import sbct_pkg::*;

    // kind code the block has no use for; it must be swallowed silently
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int REQ_W         = $bits(sbct_req_t);
    localparam int SETTLE_CYCLES = 100;     // room for a full 32-word readout to drain
    localparam int LONG_HOLD     = 400;     // receiver back-pressure burst
    localparam int CYCLE_LIMIT   = 2000000;

    // ways a generated reply can be spoilt
    typedef enum int {
        FLAW_NONE,
        FLAW_ADDRESS,
        FLAW_STATUS_PAR,
        FLAW_DATA_PAR,
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_CUT
    } reply_flaw_t;

    // everything the block sees starts at a known value
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    sbct_req_t s_req     = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    sbct_res_t m_result;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    serial_bus_command_transaction dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // requests waiting to go out, and bus results still owed by the block
    sbct_req_t requests_to_send [$];
    sbct_res_t bus_results_due [$];

    int   stim_count  = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;
    int   send_gap    = 0;
    int   hold_left   = 0;
    int   idle_left   = 0;
    logic hold_kick     = 1'b0;
    logic sender_steady = 1'b0;
    logic recv_steady   = 1'b0;

    // ------------------------------------------------------------------
    // behaviour of the bus controller, kept in step with accepted requests
    // ------------------------------------------------------------------
    logic        power_on;
    logic [4:0]  term_q;            // terminal addressed by the last command
    logic [5:0]  count_q;           // data words owed by a transmitting terminal
    logic [5:0]  send_left;         // data words still to send to a receiving terminal
    logic [15:0] reply_words [MAX_WORDS];
    logic [5:0]  reply_len;         // words of the current reply, status included
    logic [5:0]  bad_idx;           // first data word with even parity
    logic        bad_seen;
    logic [1:0]  status_flags;      // bit 0 wrong terminal, bit 1 status parity

    function automatic logic [16:0] add_parity(input logic [15:0] payload);
        int ones;
        ones = $countones(payload);
        return {payload, ones % 2 == 0};
    endfunction

    task automatic clear_reply();
        reply_len    = '0;
        bad_idx      = '0;
        bad_seen     = 1'b0;
        status_flags = '0;
    endtask

    task automatic controller_reset();
        power_on  = 1'b1;
        term_q    = '0;
        count_q   = '0;
        send_left = '0;
        foreach (reply_words[i]) reply_words[i] = '0;
        clear_reply();
    endtask

    task automatic controller_step(input sbct_req_t r);
        sbct_res_t  res;
        logic [5:0] n;
        logic [5:0] slot;
        logic [5:0] keep;
        logic [2:0] code;
        res = '0;
        case (r.kind)
            KIND_CMD: begin
                // counts above the buffer saturate; 32 goes out as zero
                n = (r.word_count > MAX_WORDS_C) ? MAX_WORDS_C : r.word_count;
                term_q = r.rt_address;
                clear_reply();
                if (r.transmit_dir) begin
                    count_q   = n;
                    send_left = '0;
                end else begin
                    count_q   = '0;
                    send_left = n;
                end
                res.result_kind  = RES_TX;
                res.bus_word_out = add_parity({r.rt_address, r.transmit_dir,
                                               r.subaddress_mode, n[4:0]});
                res.last         = (send_left == '0);
                bus_results_due = {bus_results_due, res};
            end
            KIND_DATA: begin
                // a data request with nothing left to send is dropped
                if (send_left != '0) begin
                    send_left        = send_left - 6'd1;
                    res.result_kind  = RES_TX;
                    res.bus_word_out = add_parity(r.data_word);
                    res.last         = (send_left == '0);
                    bus_results_due = {bus_results_due, res};
                end
            end
            KIND_RX: begin
                if (power_on) begin
                    if (reply_len == '0) begin
                        status_flags[0] = (r.bus_word_in[16:12] != term_q);
                        status_flags[1] = ~(^r.bus_word_in);
                    end else begin
                        // words past the buffer are counted but not kept
                        slot = reply_len - 6'd1;
                        if (slot < MAX_WORDS_C) begin
                            reply_words[slot[4:0]] = r.bus_word_in[16:1];
                            if (!bad_seen && !(^r.bus_word_in)) begin
                                bad_seen = 1'b1;
                                bad_idx  = slot;
                            end
                        end
                    end
                    if (reply_len != CNT_SAT) reply_len = reply_len + 6'd1;
                    if (r.rx_last) begin
                        // address beats status parity beats length
                        if (status_flags[0]) begin
                            code = REJ_ADDRESS;
                        end else if (status_flags[1]) begin
                            code = REJ_STATUS_PAR;
                        end else if ({1'b0, reply_len} != {1'b0, count_q} + 7'd1) begin
                            code = REJ_LENGTH;
                        end else begin
                            code = REJ_OK;
                        end
                        keep = '0;
                        if (code == REJ_OK) begin
                            keep = count_q;
                            if (bad_seen && bad_idx < keep) begin
                                keep = bad_idx;
                                code = REJ_DATA_PAR;
                            end
                            for (int i = 0; i < keep; i++) begin
                                res             = '0;
                                res.result_kind = RES_DATA;
                                res.data_out    = reply_words[i];
                                bus_results_due = {bus_results_due, res};
                            end
                        end
                        res                = '0;
                        res.result_kind    = RES_OUTCOME;
                        res.reject_code    = code;
                        res.words_accepted = keep;
                        res.last           = 1'b1;
                        bus_results_due = {bus_results_due, res};
                        clear_reply();
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request builders; unused fields carry random bits
    // ------------------------------------------------------------------
    function automatic sbct_req_t filler();
        return sbct_req_t'(REQ_W'({$urandom(), $urandom()}));
    endfunction

    task automatic push_cmd(input logic [4:0] rt, input logic dir, input logic [4:0] sa,
                            input logic [5:0] wc);
        sbct_req_t r;
        r                 = filler();
        r.kind            = KIND_CMD;
        r.rt_address      = rt;
        r.transmit_dir    = dir;
        r.subaddress_mode = sa;
        r.word_count      = wc;
        requests_to_send = {requests_to_send, r};
        stim_count++;
    endtask

    task automatic push_data(input logic [15:0] dw, input logic counted);
        sbct_req_t r;
        r           = filler();
        r.kind      = KIND_DATA;
        r.data_word = dw;
        requests_to_send = {requests_to_send, r};
        if (counted) stim_count++;
    endtask

    task automatic push_rx(input logic [16:0] bw, input logic last_word);
        sbct_req_t r;
        r             = filler();
        r.kind        = KIND_RX;
        r.bus_word_in = bw;
        r.rx_last     = last_word;
        requests_to_send = {requests_to_send, r};
        stim_count++;
    endtask

    task automatic push_junk();
        sbct_req_t r;
        r      = filler();
        r.kind = KIND_UNUSED;
        requests_to_send = {requests_to_send, r};
    endtask

    // status word then data words, spoilt as asked
    task automatic push_reply(input logic [4:0] rt, input int n_words, input reply_flaw_t flaw);
        logic [15:0] status;
        logic [16:0] w;
        int          words;
        int          bad_at;
        words  = n_words;
        bad_at = -1;
        case (flaw)
            FLAW_SHORT:      words = (n_words > 0) ? n_words - 1 : 1;
            FLAW_LONG:       words = n_words + $urandom_range(1, 8);
            FLAW_CUT:        words = $urandom_range(0, n_words);
            FLAW_STATUS_PAR: if ($urandom_range(0, 1) == 1) words = n_words + 1;
            FLAW_DATA_PAR:   if (n_words > 0) bad_at = $urandom_range(0, n_words - 1);
            default: begin
            end
        endcase
        status        = 16'($urandom());
        status[15:11] = rt;
        if (flaw == FLAW_ADDRESS) status[15:11] = rt ^ 5'($urandom_range(1, 31));
        w = add_parity(status);
        if (flaw == FLAW_STATUS_PAR || (flaw == FLAW_ADDRESS && $urandom_range(0, 1) == 1)) begin
            w[0] = ~w[0];
        end
        push_rx(w, words == 0 && flaw != FLAW_CUT);
        for (int i = 0; i < words; i++) begin
            w = add_parity(16'($urandom()));
            if (i == bad_at || (bad_at >= 0 && i > bad_at && $urandom_range(0, 3) == 0)) begin
                w[0] = ~w[0];
            end
            push_rx(w, i == words - 1 && flaw != FLAW_CUT);
        end
    endtask

    // mostly short transfers, now and then up to the full buffer
    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return $urandom_range(1, 4);
        if (roll < 88) return $urandom_range(5, 12);
        return $urandom_range(13, 32);
    endfunction

    task automatic random_transaction();
        int          sel;
        int          n;
        int          wc;
        logic        dir;
        logic [4:0]  rt;
        logic [4:0]  sa;
        reply_flaw_t flaw;
        rt  = 5'($urandom());
        sa  = 5'($urandom());
        n   = pick_count();
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            // clean transmit transfer, sometimes with a bad data word
            push_cmd(rt, 1'b1, sa, 6'(n));
            push_reply(rt, n, ($urandom_range(0, 5) == 0) ? FLAW_DATA_PAR : FLAW_NONE);
        end else if (sel < 65) begin
            // receive transfer, now and then a surplus data request
            push_cmd(rt, 1'b0, sa, 6'(n));
            for (int i = 0; i < n; i++) push_data(16'($urandom()), 1'b1);
            if ($urandom_range(0, 5) == 0) push_data(16'($urandom()), 1'b0);
        end else if (sel < 75) begin
            case ($urandom_range(0, 3))
                0:       flaw = FLAW_ADDRESS;
                1:       flaw = FLAW_STATUS_PAR;
                2:       flaw = FLAW_SHORT;
                default: flaw = FLAW_LONG;
            endcase
            push_cmd(rt, 1'b1, sa, 6'(n));
            push_reply(rt, n, flaw);
        end else if (sel < 81) begin
            // reply broken off by the next command
            push_cmd(rt, 1'b1, sa, 6'(n));
            push_reply(rt, n, FLAW_CUT);
        end else if (sel < 86) begin
            push_cmd(rt, 1'b0, sa, 6'(n));
            for (int i = 0; i < $urandom_range(0, n - 1); i++) push_data(16'($urandom()), 1'b1);
        end else if (sel < 91) begin
            push_rx(17'($urandom()), 1'($urandom_range(0, 1)));
        end else if (sel < 94) begin
            push_junk();
        end else begin
            // zero count or a count beyond the buffer
            wc  = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(33, 63);
            dir = 1'($urandom_range(0, 1));
            n   = (wc == 0) ? 0 : MAX_WORDS;
            push_cmd(rt, dir, sa, 6'(wc));
            if (dir) begin
                push_reply(rt, n, FLAW_NONE);
            end else begin
                for (int i = 0; i < n; i++) push_data(16'($urandom()), 1'b1);
            end
        end
    endtask

    task automatic random_batch(input int quota);
        int goal;
        goal = stim_count + quota;
        while (stim_count < goal) random_transaction();
    endtask

    // sender drained and every owed result back, then room for a readout to finish
    task automatic settle();
        @(negedge aclk);
        while (requests_to_send.size() != 0 || s_valid || bus_results_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // the block is idle whenever this is called
    task automatic write_power(input logic on);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        power_on = on;
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // request driver: predicts on each accepted request, then loads the next
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) controller_step(s_req);
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (requests_to_send.size() != 0) begin
                    s_req    <= requests_to_send.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= (sender_steady || $urandom_range(0, 1) == 0) ? 0 : gap_length();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stalls, plus one long hold when kicked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            idle_left <= 0;
        end else if (hold_kick) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (recv_steady) begin
            m_ready <= 1'b1;
        end else if (idle_left != 0) begin
            m_ready   <= 1'b0;
            idle_left <= idle_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            m_ready   <= 1'b0;
            idle_left <= gap_length() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor: every accepted result against the oldest one owed
    always @(posedge aclk) begin
        sbct_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bus_results_due.size() == 0) begin
                $error("result with none owed: %p", m_result);
                mismatches++;
            end else begin
                want = bus_results_due.pop_front();
                if (m_result.result_kind !== want.result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, m_result.result_kind);
                    mismatches++;
                end
                if (m_result.bus_word_out !== want.bus_word_out) begin
                    $error("bus_word_out: expected %h, got %h",
                           want.bus_word_out, m_result.bus_word_out);
                    mismatches++;
                end
                if (m_result.data_out !== want.data_out) begin
                    $error("data_out: expected %h, got %h", want.data_out, m_result.data_out);
                    mismatches++;
                end
                if (m_result.reject_code !== want.reject_code) begin
                    $error("reject_code: expected %0d, got %0d",
                           want.reject_code, m_result.reject_code);
                    mismatches++;
                end
                if (m_result.words_accepted !== want.words_accepted) begin
                    $error("words_accepted: expected %0d, got %0d",
                           want.words_accepted, m_result.words_accepted);
                    mismatches++;
                end
                if (m_result.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_result.last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        controller_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_power(1'b1);

        // field extremes and the corner cases, one request at a time in spirit
        push_cmd(5'd31, 1'b1, 5'd31, 6'd32);                  // full count goes out as zero
        push_cmd(5'd0, 1'b0, 5'd0, 6'd0);                     // zero count, command ends the run
        push_cmd(5'd5, 1'b0, 5'd3, 6'd63);                    // count saturates at the buffer size
        push_data(16'hFFFF, 1'b1);
        push_cmd(5'd7, 1'b0, 5'd1, 6'd2);                     // cuts the send above short
        push_data(16'hFFFF, 1'b1);
        push_data(16'h0000, 1'b1);
        push_data(16'h1234, 1'b0);                            // surplus, nothing to send
        push_cmd(5'd9, 1'b1, 5'd4, 6'd2);
        push_rx(add_parity({5'd9, 11'h7FF}), 1'b0);
        push_rx(add_parity(16'hFFFF), 1'b0);
        push_rx(add_parity(16'h0000) ^ 17'd1, 1'b1);         // readout stops at bad data parity
        push_cmd(5'd9, 1'b1, 5'd4, 6'd1);
        push_rx(add_parity({5'd8, 11'h000}), 1'b0);           // wrong terminal answers
        push_rx(add_parity(16'h0001), 1'b1);
        push_cmd(5'd3, 1'b1, 5'd2, 6'd1);
        push_rx(add_parity({5'd3, 11'h2AA}) ^ 17'd1, 1'b0);  // status parity error
        push_rx(add_parity(16'hABCD), 1'b1);
        push_cmd(5'd3, 1'b1, 5'd2, 6'd2);
        push_rx(add_parity({5'd3, 11'h155}), 1'b0);
        push_rx(add_parity(16'h5555), 1'b1);                  // reply one word short
        push_junk();
        push_rx(17'h1FFFF, 1'b1);                             // lone all-ones status
        push_rx(17'h00000, 1'b1);                             // lone all-zero status
        push_cmd(5'd12, 1'b1, 5'd7, 6'd2);
        push_rx(add_parity({5'd12, 11'h3C3}), 1'b0);          // reply left open over power-down
        settle();

        // unpowered: bus words leave no trace; a surplus data request is still dropped
        write_power(1'b0);
        push_rx(add_parity(16'hFFFF), 1'b0);
        push_rx(17'($urandom()), 1'b1);
        push_data(16'hBEEF, 1'b0);
        push_junk();
        settle();

        // powered again: the open reply picks up where it stopped
        write_power(1'b1);
        push_rx(add_parity(16'h8001), 1'b0);
        push_rx(add_parity(16'h7FFE), 1'b1);

        // random traffic with a long receiver hold so the block backs up
        random_batch(10);
        push_cmd(5'($urandom()), 1'b1, 5'($urandom()), 6'd32);
        push_reply(5'($urandom()), 70, FLAW_NONE);            // overlong reply, count saturates
        random_batch(8);
        hold_kick <= 1'b1;
        @(posedge aclk);
        hold_kick <= 1'b0;
        settle();

        // a stretch with no idling on either side
        sender_steady <= 1'b1;
        recv_steady   <= 1'b1;
        random_batch(10);
        settle();
        sender_steady <= 1'b0;
        recv_steady   <= 1'b0;

        write_power(1'b0);
        random_batch(4);
        settle();
        write_power(1'b1);
        random_batch(10);
        settle();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
